/* design/multi_pattern_byte_replacer_defines.svh */
// Assertion macros for the multi-pattern byte replacer checker.
`ifndef MULTI_PATTERN_BYTE_REPLACER_DEFINES_SVH
`define MULTI_PATTERN_BYTE_REPLACER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define MPBR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mpbr assertion failed");

// Next-cycle implication, disabled during reset
`define MPBR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mpbr assertion failed");

// Next-cycle implication that also runs through reset
`define MPBR_ASSERT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("mpbr reset assertion failed");

`endif

/* design/mpbr_pkg.sv */
// Shared constants and command codes of the multi-pattern byte replacer.
`default_nettype none
package mpbr_pkg;

    localparam int DEF_MAX_RULES       = 8;
    localparam int DEF_MAX_SEARCH_LEN  = 8;
    localparam int DEF_MAX_REPLACE_LEN = 8;

    localparam int BYTE_W      = 8;
    localparam int CMD_W       = 3;
    localparam int FIELD_IDX_W = 3;
    localparam int LEN_FIELD_W = 4;
    localparam int CFG_W       = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_SEARCH  = 3'd0,
        CMD_LOAD_REPLACE = 3'd1,
        CMD_SET_LENS     = 3'd2,
        CMD_DATA         = 3'd3,
        CMD_END          = 3'd4
    } cmd_t;

endpackage
`default_nettype wire

/* design/multi_pattern_byte_replacer.sv */
// Load, set-length and unused commands are taken in the idle state. A data or end item
// resolves the window: each decision scans window positions from the oldest, reading the
// search row and then comparing at each position, then emits a literal or reads and emits
// each replacement byte in turn, then finishes. Output stalls hold the emit and finish
// steps. Reset (aresetn low, synchronous) clears the rule count, sets all lengths to one
// and empties the window; table memories are not cleared.
`default_nettype none
module multi_pattern_byte_replacer import mpbr_pkg::*; #(
    parameter int MAX_RULES       = DEF_MAX_RULES,
    parameter int MAX_SEARCH_LEN  = DEF_MAX_SEARCH_LEN,
    parameter int MAX_REPLACE_LEN = DEF_MAX_REPLACE_LEN
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [CMD_W-1:0]       s_cmd,
    input  logic [FIELD_IDX_W-1:0] s_rule_index,
    input  logic [FIELD_IDX_W-1:0] s_byte_pos,
    input  logic [BYTE_W-1:0]      s_byte_value,
    input  logic [LEN_FIELD_W-1:0] s_search_length,
    input  logic [LEN_FIELD_W-1:0] s_replace_length,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [BYTE_W-1:0]      m_out_byte,
    output logic                   m_last
);

    localparam int RI_W   = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CI_W   = $clog2(MAX_SEARCH_LEN);
    localparam int FILL_W = $clog2(MAX_SEARCH_LEN + 1);
    localparam int K_W    = (MAX_REPLACE_LEN > 1) ? $clog2(MAX_REPLACE_LEN) : 1;
    localparam int RL_W   = $clog2(MAX_REPLACE_LEN + 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_RD, ST_CMP, ST_LIT, ST_REP_RD, ST_REP, ST_FIN
    } state_t;

    state_t                 state_reg, state_next;
    logic [CFG_W-1:0]       rule_count_reg, rule_count_next;
    logic [FILL_W-1:0]      slen_reg [MAX_RULES];
    logic [FILL_W-1:0]      slen_next [MAX_RULES];
    logic [RL_W-1:0]        rlen_reg [MAX_RULES];
    logic [RL_W-1:0]        rlen_next [MAX_RULES];
    logic [BYTE_W-1:0]      window_reg [MAX_SEARCH_LEN];
    logic [BYTE_W-1:0]      window_next [MAX_SEARCH_LEN];
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [CI_W-1:0]        ci_reg, ci_next;
    logic [MAX_RULES-1:0]   alive_reg, alive_next;
    logic                   ending_reg, ending_next;
    logic [RI_W-1:0]        hit_reg, hit_next;
    logic [K_W-1:0]         k_reg, k_next;
    logic                   hold_valid_reg, hold_valid_next;
    logic [BYTE_W-1:0]      hold_byte_reg, hold_byte_next;
    logic                   m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]      m_byte_reg, m_byte_next;
    logic                   m_last_reg, m_last_next;

    logic [MAX_RULES-1:0][BYTE_W-1:0] srch_row;
    logic [BYTE_W-1:0]      rep_data;
    logic                   srch_we, rep_we;
    logic                   ri_ok, spos_ok, rpos_ok;
    logic [FILL_W-1:0]      slen_in;
    logic [RL_W-1:0]        rlen_in;
    logic [MAX_RULES-1:0]   in_use, hit_vec, alive_nx, pend;
    logic                   hit_any, ci_last, out_free, can_emit;
    logic [RI_W-1:0]        hit_idx;
    logic [BYTE_W-1:0]      win_ci;
    logic                   emit_en, drop_en, rescan, out_load, out_last;
    logic [BYTE_W-1:0]      emit_byte, out_byte;
    logic [FILL_W-1:0]      drop_cnt, fill_left, data_fill;
    logic                   active, eq;
    int                     src;

    assign cfg_ready  = 1'b1;
    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_byte_reg;
    assign m_last     = m_last_reg;

    // Decode load addressing and clamp lengths
    assign ri_ok   = 32'(s_rule_index) < MAX_RULES;
    assign spos_ok = 32'(s_byte_pos) < MAX_SEARCH_LEN;
    assign rpos_ok = 32'(s_byte_pos) < MAX_REPLACE_LEN;
    assign slen_in = (s_search_length == '0) ? FILL_W'(1) :
                     (32'(s_search_length) > MAX_SEARCH_LEN) ? FILL_W'(MAX_SEARCH_LEN) :
                     FILL_W'(s_search_length);
    assign rlen_in = (s_replace_length == '0) ? RL_W'(1) :
                     (32'(s_replace_length) > MAX_REPLACE_LEN) ? RL_W'(MAX_REPLACE_LEN) :
                     RL_W'(s_replace_length);
    assign srch_we = s_ready && s_valid && (s_cmd == CMD_LOAD_SEARCH) && ri_ok && spos_ok;
    assign rep_we  = s_ready && s_valid && (s_cmd == CMD_LOAD_REPLACE) && ri_ok && rpos_ok;

    mpbr_search_mem #(
        .MAX_RULES      (MAX_RULES),
        .MAX_SEARCH_LEN (MAX_SEARCH_LEN)
    ) u_search_mem (
        .aclk    (aclk),
        .wr_en   (srch_we),
        .wr_row  (CI_W'(s_byte_pos)),
        .wr_lane (RI_W'(s_rule_index)),
        .wr_byte (s_byte_value),
        .rd_row  (ci_reg),
        .rd_data (srch_row)
    );

    mpbr_replace_mem #(
        .MAX_RULES       (MAX_RULES),
        .MAX_REPLACE_LEN (MAX_REPLACE_LEN)
    ) u_replace_mem (
        .aclk    (aclk),
        .wr_en   (rep_we),
        .wr_rule (RI_W'(s_rule_index)),
        .wr_pos  (K_W'(s_byte_pos)),
        .wr_byte (s_byte_value),
        .rd_rule (hit_reg),
        .rd_pos  (k_reg),
        .rd_data (rep_data)
    );

    // Compare the search row against the window byte at the scan position
    always_comb begin
        active  = 1'b0;
        eq      = 1'b0;
        win_ci  = window_reg[ci_reg];
        hit_idx = '0;
        for (int r = 0; r < MAX_RULES; r++) begin
            in_use[r]   = 32'(rule_count_reg) > r;
            active      = alive_reg[r] && (32'(slen_reg[r]) > 32'(ci_reg));
            eq          = (srch_row[r] == win_ci);
            hit_vec[r]  = active && eq && (32'(slen_reg[r]) == 32'(ci_reg) + 1);
            alive_nx[r] = alive_reg[r] && !(active && !eq);
            pend[r]     = alive_nx[r] && (slen_reg[r] > fill_reg);
        end
        for (int r = MAX_RULES - 1; r >= 0; r--) begin
            if (hit_vec[r]) begin
                hit_idx = RI_W'(r);
            end
        end
        hit_any = |hit_vec;
        ci_last = (32'(ci_reg) + 1 == 32'(fill_reg));
    end

    // Sequence loads, window scans and output
    always_comb begin
        state_next      = state_reg;
        rule_count_next = rule_count_reg;
        slen_next       = slen_reg;
        rlen_next       = rlen_reg;
        window_next     = window_reg;
        fill_next       = fill_reg;
        ci_next         = ci_reg;
        alive_next      = alive_reg;
        ending_next     = ending_reg;
        hit_next        = hit_reg;
        k_next          = k_reg;
        hold_valid_next = hold_valid_reg;
        hold_byte_next  = hold_byte_reg;
        m_byte_next     = m_byte_reg;
        m_last_next     = m_last_reg;
        out_free        = !m_valid_reg || m_ready;
        can_emit        = !hold_valid_reg || out_free;
        emit_en         = 1'b0;
        emit_byte       = window_reg[0];
        drop_en         = 1'b0;
        drop_cnt        = '0;
        rescan          = 1'b0;
        out_load        = 1'b0;
        out_last        = 1'b0;
        out_byte        = hold_byte_reg;
        fill_left       = fill_reg;
        data_fill       = fill_reg;
        src             = 0;

        if (cfg_valid) begin
            rule_count_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_cmd)
                        CMD_SET_LENS: begin
                            if (ri_ok) begin
                                slen_next[RI_W'(s_rule_index)] = slen_in;
                                rlen_next[RI_W'(s_rule_index)] = rlen_in;
                            end
                        end
                        CMD_DATA: begin
                            if (32'(fill_reg) < MAX_SEARCH_LEN) begin
                                window_next[CI_W'(fill_reg)] = s_byte_value;
                                data_fill = fill_reg + FILL_W'(1);
                            end
                            fill_next   = data_fill;
                            fill_left   = data_fill;
                            ending_next = 1'b0;
                            rescan      = 1'b1;
                        end
                        CMD_END: begin
                            ending_next = 1'b1;
                            rescan      = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RD: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (hit_any) begin
                    hit_next   = hit_idx;
                    k_next     = '0;
                    state_next = ST_REP_RD;
                end else if (alive_nx == '0) begin
                    state_next = ST_LIT;
                end else if (ci_last) begin
                    state_next = (!ending_reg && (|pend)) ? ST_FIN : ST_LIT;
                end else begin
                    ci_next    = ci_reg + CI_W'(1);
                    alive_next = alive_nx;
                    state_next = ST_RD;
                end
            end
            ST_LIT: begin
                if (can_emit) begin
                    emit_en   = 1'b1;
                    emit_byte = window_reg[0];
                    drop_en   = 1'b1;
                    drop_cnt  = FILL_W'(1);
                    rescan    = 1'b1;
                end
            end
            ST_REP_RD: begin
                state_next = ST_REP;
            end
            ST_REP: begin
                if (can_emit) begin
                    emit_en   = 1'b1;
                    emit_byte = rep_data;
                    if (32'(k_reg) + 1 == 32'(rlen_reg[hit_reg])) begin
                        drop_en  = 1'b1;
                        drop_cnt = slen_reg[hit_reg];
                        rescan   = 1'b1;
                    end else begin
                        k_next     = k_reg + K_W'(1);
                        state_next = ST_REP_RD;
                    end
                end
            end
            ST_FIN: begin
                if (!hold_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_load        = 1'b1;
                    out_last        = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
                if (ending_reg) begin
                    fill_next = '0;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Drop resolved bytes from the head of the window
        if (drop_en) begin
            for (int i = 0; i < MAX_SEARCH_LEN; i++) begin
                src = i + int'(drop_cnt);
                if (src < MAX_SEARCH_LEN) begin
                    window_next[i] = window_reg[CI_W'(src)];
                end
            end
            fill_left = fill_reg - drop_cnt;
            fill_next = fill_left;
        end

        // Restart the scan at the oldest byte
        if (rescan) begin
            ci_next    = '0;
            alive_next = in_use;
            state_next = (fill_left != '0) ? ST_RD : ST_FIN;
        end

        // Hold the newest byte back until it is known whether it ends the item
        if (emit_en) begin
            if (hold_valid_reg) begin
                out_load = 1'b1;
            end
            hold_byte_next  = emit_byte;
            hold_valid_next = 1'b1;
        end

        if (out_load) begin
            m_byte_next = out_byte;
            m_last_next = out_last;
        end
        m_valid_next = out_load || (m_valid_reg && !m_ready);
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        window_reg    <= window_next;
        ci_reg        <= ci_next;
        alive_reg     <= alive_next;
        ending_reg    <= ending_next;
        hit_reg       <= hit_next;
        k_reg         <= k_next;
        hold_byte_reg <= hold_byte_next;
        m_byte_reg    <= m_byte_next;
        m_last_reg    <= m_last_next;
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            rule_count_reg <= '0;
            for (int r = 0; r < MAX_RULES; r++) begin
                slen_reg[r] <= FILL_W'(1);
                rlen_reg[r] <= RL_W'(1);
            end
            fill_reg       <= '0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            rule_count_reg <= rule_count_next;
            slen_reg       <= slen_next;
            rlen_reg       <= rlen_next;
            fill_reg       <= fill_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

endmodule
`default_nettype wire

/* design/mpbr_search_mem.sv */
// Search byte memory: one row per string position, one byte lane per rule.
`default_nettype none
module mpbr_search_mem import mpbr_pkg::*; #(
    parameter int MAX_RULES      = DEF_MAX_RULES,
    parameter int MAX_SEARCH_LEN = DEF_MAX_SEARCH_LEN,
    localparam int RI_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1,
    localparam int CI_W = $clog2(MAX_SEARCH_LEN)
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [CI_W-1:0]                       wr_row,
    input  logic [RI_W-1:0]                       wr_lane,
    input  logic [BYTE_W-1:0]                     wr_byte,
    input  logic [CI_W-1:0]                       rd_row,
    output logic [MAX_RULES-1:0][BYTE_W-1:0]      rd_data
);

    logic [MAX_RULES-1:0][BYTE_W-1:0] mem [MAX_SEARCH_LEN];

    // Write one lane, read a whole row
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_row][wr_lane] <= wr_byte;
        end
        rd_data <= mem[rd_row];
    end

endmodule
`default_nettype wire

/* design/mpbr_replace_mem.sv */
// Replacement byte memory, addressed by rule and position.
`default_nettype none
module mpbr_replace_mem import mpbr_pkg::*; #(
    parameter int MAX_RULES       = DEF_MAX_RULES,
    parameter int MAX_REPLACE_LEN = DEF_MAX_REPLACE_LEN,
    localparam int RI_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1,
    localparam int K_W  = (MAX_REPLACE_LEN > 1) ? $clog2(MAX_REPLACE_LEN) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [RI_W-1:0]   wr_rule,
    input  logic [K_W-1:0]    wr_pos,
    input  logic [BYTE_W-1:0] wr_byte,
    input  logic [RI_W-1:0]   rd_rule,
    input  logic [K_W-1:0]    rd_pos,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem [MAX_RULES][MAX_REPLACE_LEN];

    // Single write port, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_rule][wr_pos] <= wr_byte;
        end
        rd_data <= mem[rd_rule][rd_pos];
    end

endmodule
`default_nettype wire

/* design/mpbr_checker.sv */
// Port-level checker for the multi-pattern byte replacer, bound to the top level.
`default_nettype none
`include "multi_pattern_byte_replacer_defines.svh"
module mpbr_checker import mpbr_pkg::*; (
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   cfg_valid,
    input wire logic                   cfg_ready,
    input wire logic [CFG_W-1:0]       cfg_data,
    input wire logic                   s_valid,
    input wire logic                   s_ready,
    input wire logic [CMD_W-1:0]       s_cmd,
    input wire logic [FIELD_IDX_W-1:0] s_rule_index,
    input wire logic [FIELD_IDX_W-1:0] s_byte_pos,
    input wire logic [BYTE_W-1:0]      s_byte_value,
    input wire logic [LEN_FIELD_W-1:0] s_search_length,
    input wire logic [LEN_FIELD_W-1:0] s_replace_length,
    input wire logic                   m_valid,
    input wire logic                   m_ready,
    input wire logic [BYTE_W-1:0]      m_out_byte,
    input wire logic                   m_last
);

    logic load_acc;

    assign load_acc = s_valid && s_ready &&
                      (s_cmd == CMD_LOAD_SEARCH || s_cmd == CMD_LOAD_REPLACE ||
                       s_cmd == CMD_SET_LENS);

    // Stalled result holds
    `MPBR_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_out_byte) && $stable(m_last))

    // Reset leaves the block ready with no result pending
    `MPBR_ASSERT_RST(a_reset_idle, aclk, !aresetn, s_ready && !m_valid)

    // The block is ready again in the cycle after a table load
    `MPBR_ASSERT_NXT(a_load_one_cycle, aclk, aresetn, load_acc, s_ready)

    // Table loads produce no result
    `MPBR_ASSERT_NXT(a_load_silent, aclk, aresetn, load_acc && !m_valid, !m_valid)

endmodule

bind multi_pattern_byte_replacer mpbr_checker u_mpbr_checker (.*);
`default_nettype wire

/* tb/multi_pattern_byte_replacer_tb.sv */
// Self-checking testbench for the multi-pattern byte replacer: rule loads, matching, flushes.
`default_nettype none
module multi_pattern_byte_replacer_tb;
    import mpbr_pkg::*;

    localparam int NRULES   = DEF_MAX_RULES;
    localparam int SLEN_MAX = DEF_MAX_SEARCH_LEN;
    localparam int RLEN_MAX = DEF_MAX_REPLACE_LEN;
    localparam int OUT_CAP  = 64;
    localparam int SETTLE   = 300;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } out_beat_t;

    logic aclk;
    logic aresetn;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_W-1:0] cfg_data;
    logic s_valid;
    logic s_ready;
    logic [CMD_W-1:0] s_cmd;
    logic [FIELD_IDX_W-1:0] s_rule_index;
    logic [FIELD_IDX_W-1:0] s_byte_pos;
    logic [BYTE_W-1:0] s_byte_value;
    logic [LEN_FIELD_W-1:0] s_search_length;
    logic [LEN_FIELD_W-1:0] s_replace_length;
    logic m_valid;
    logic m_ready;
    logic [BYTE_W-1:0] m_out_byte;
    logic m_last;

    // Shadow copy of the block state
    logic [7:0] pat_tbl [NRULES][SLEN_MAX];
    logic [7:0] sub_tbl [NRULES][RLEN_MAX];
    int unsigned pat_len [NRULES];
    int unsigned sub_len [NRULES];
    logic [7:0] win [SLEN_MAX];
    int unsigned win_fill;
    int unsigned active_rules;

    out_beat_t expected_bytes [$];
    int errors;
    bit quiet;
    int stall_left;

    multi_pattern_byte_replacer u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_rule_index(s_rule_index), .s_byte_pos(s_byte_pos),
        .s_byte_value(s_byte_value), .s_search_length(s_search_length),
        .s_replace_length(s_replace_length),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_byte(m_out_byte), .m_last(m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (quiet || r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // Result-side backpressure
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            int g;
            g = pick_gap();
            m_ready <= (g == 0);
            stall_left <= (g > 0) ? g - 1 : 0;
        end
    end

    // 0: undecided, 1: literal, 2: rule hit
    function automatic int decide_head(bit ending, output int unsigned hit);
        int unsigned rc;
        logic [NRULES-1:0] alive;
        rc = (active_rules > NRULES) ? NRULES : active_rules;
        alive = '1;
        hit = 0;
        for (int unsigned ci = 0; ci < SLEN_MAX; ci++) begin
            for (int unsigned r = 0; r < rc; r++) begin
                if (!alive[r] || pat_len[r] <= ci) continue;
                if (ci >= win_fill) begin
                    if (!ending) return 0;
                    alive[r] = 1'b0;
                    continue;
                end
                if (win[ci] == pat_tbl[r][ci]) begin
                    if (ci + 1 == pat_len[r]) begin
                        hit = r;
                        return 2;
                    end
                end else begin
                    alive[r] = 1'b0;
                end
            end
        end
        return 1;
    endfunction

    function automatic void shift_window(int unsigned count);
        if (count > win_fill) count = win_fill;
        for (int unsigned i = 0; i + count < win_fill; i++) win[i] = win[i + count];
        win_fill -= count;
    endfunction

    function automatic int resolve_window(bit ending);
        int n;
        int d;
        int unsigned hit;
        n = 0;
        while (win_fill > 0) begin
            d = decide_head(ending, hit);
            if (d == 0) break;
            if (d == 2) begin
                for (int unsigned k = 0; k < sub_len[hit]; k++) begin
                    if (n < OUT_CAP) begin
                        expected_bytes.push_back('{sub_tbl[hit][k], 1'b0});
                        n++;
                    end
                end
                shift_window(pat_len[hit]);
            end else begin
                if (n < OUT_CAP) begin
                    expected_bytes.push_back('{win[0], 1'b0});
                    n++;
                end
                shift_window(1);
            end
        end
        return n;
    endfunction

    function automatic int unsigned clamp_len(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Apply one accepted item to the shadow state and queue its output bytes
    function automatic void predict_replacer(logic [2:0] cmd, logic [2:0] ri, logic [2:0] pos,
                                             logic [7:0] val, logic [3:0] sl, logic [3:0] rl);
        int n;
        n = 0;
        case (cmd)
            CMD_LOAD_SEARCH:  pat_tbl[ri][pos] = val;
            CMD_LOAD_REPLACE: sub_tbl[ri][pos] = val;
            CMD_SET_LENS: begin
                pat_len[ri] = clamp_len(sl, SLEN_MAX);
                sub_len[ri] = clamp_len(rl, RLEN_MAX);
            end
            CMD_DATA: begin
                if (win_fill < SLEN_MAX) begin
                    win[win_fill] = val;
                    win_fill++;
                end
                n = resolve_window(1'b0);
            end
            CMD_END: begin
                n = resolve_window(1'b1);
                win_fill = 0;
            end
            default: ;
        endcase
        if (n > 0) expected_bytes[$].last = 1'b1;
    endfunction

    // Compare each accepted output byte with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected output byte %h last %b", $time, m_out_byte, m_last);
                errors++;
            end else begin
                out_beat_t e;
                e = expected_bytes.pop_front();
                if (e.out_byte !== m_out_byte) begin
                    $display("%0t: out_byte expected %h actual %h", $time, e.out_byte, m_out_byte);
                    errors++;
                end
                if (e.last !== m_last) begin
                    $display("%0t: last expected %b actual %b", $time, e.last, m_last);
                    errors++;
                end
            end
        end
    end

    // Send one item, hold it until accepted, then update the prediction
    task automatic send_item(logic [2:0] cmd, logic [2:0] ri, logic [2:0] pos,
                             logic [7:0] val, logic [3:0] sl, logic [3:0] rl);
        int g;
        g = pick_gap();
        @(negedge aclk);
        if (g > 0) begin
            s_valid = 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_cmd = cmd;
        s_rule_index = ri;
        s_byte_pos = pos;
        s_byte_value = val;
        s_search_length = sl;
        s_replace_length = rl;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_replacer(cmd, ri, pos, val, sl, rl);
    endtask

    // Let every expected byte arrive, then give the block time to go idle
    task automatic drain_all();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_rule_count(logic [3:0] v);
        @(negedge aclk);
        cfg_data = v;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        active_rules = v;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [7:0] alpha_byte();
        return 8'(8'h61 + $urandom_range(0, 3));
    endfunction

    // Fill every table entry so no unwritten byte is ever read
    task automatic test_load_tables();
        for (int r = 0; r < NRULES; r++) begin
            for (int p = 0; p < SLEN_MAX; p++)
                send_item(CMD_LOAD_SEARCH, 3'(r), 3'(p), alpha_byte(), 0, 0);
            for (int p = 0; p < RLEN_MAX; p++)
                send_item(CMD_LOAD_REPLACE, 3'(r), 3'(p), 8'($urandom_range(0, 255)), 0, 0);
            send_item(CMD_SET_LENS, 3'(r), 0, 0, 4'($urandom_range(1, 3)),
                      4'($urandom_range(1, 4)));
        end
        drain_all();
    endtask

    task automatic test_directed();
        // no rules: literals right away, end with empty window
        send_item(CMD_DATA, 0, 0, 8'h00, 0, 0);
        send_item(CMD_DATA, 0, 0, 8'hFF, 0, 0);
        send_item(CMD_END, 0, 0, 0, 0, 0);
        drain_all();
        write_rule_count(4'd8);
        // rule 0 = "ab" -> 3 bytes
        send_item(CMD_LOAD_SEARCH, 0, 0, 8'h61, 0, 0);
        send_item(CMD_LOAD_SEARCH, 0, 1, 8'h62, 0, 0);
        send_item(CMD_SET_LENS, 0, 0, 0, 4'd2, 4'd3);
        send_item(CMD_DATA, 0, 0, 8'h61, 0, 0);
        send_item(CMD_DATA, 0, 0, 8'h62, 0, 0);
        // clamped lengths: zero and above maximum
        send_item(CMD_SET_LENS, 7, 0, 0, 4'd0, 4'd15);
        send_item(CMD_SET_LENS, 6, 0, 0, 4'd15, 4'd0);
        send_item(CMD_LOAD_SEARCH, 7, 7, 8'hFF, 0, 0);
        send_item(CMD_LOAD_REPLACE, 7, 7, 8'h00, 0, 0);
        // pending bytes, table change, then flush
        send_item(CMD_DATA, 0, 0, 8'h63, 0, 0);
        send_item(CMD_DATA, 0, 0, 8'h64, 0, 0);
        send_item(CMD_LOAD_SEARCH, 3, 0, 8'h63, 0, 0);
        send_item(CMD_END, 0, 0, 0, 0, 0);
        send_item(CMD_END, 0, 0, 0, 0, 0);
        // unused codes are ignored
        send_item(3'd5, 1, 2, 8'h55, 4'd3, 4'd3);
        send_item(3'd6, 2, 3, 8'hAA, 4'd5, 4'd5);
        send_item(3'd7, 7, 7, 8'hFF, 4'd15, 4'd15);
        send_item(CMD_DATA, 0, 0, 8'h80, 0, 0);
        send_item(CMD_END, 0, 0, 0, 0, 0);
        drain_all();
    endtask

    task automatic test_random_phase(logic [3:0] rc, int count);
        int r;
        write_rule_count(rc);
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (i % 40 == 0) quiet = ~quiet;
            if (r < 68)
                send_item(CMD_DATA, 3'($urandom), 3'($urandom),
                          ($urandom_range(0, 4) != 0) ? alpha_byte() : 8'($urandom), 0, 0);
            else if (r < 78)
                send_item(CMD_END, 3'($urandom), 3'($urandom), 8'($urandom),
                          4'($urandom), 4'($urandom));
            else if (r < 85)
                send_item(CMD_LOAD_SEARCH, 3'($urandom), 3'($urandom),
                          ($urandom_range(0, 3) != 0) ? alpha_byte() : 8'($urandom), 0, 0);
            else if (r < 91)
                send_item(CMD_LOAD_REPLACE, 3'($urandom), 3'($urandom), 8'($urandom), 0, 0);
            else if (r < 97)
                send_item(CMD_SET_LENS, 3'($urandom), 3'($urandom), 8'($urandom),
                          ($urandom_range(0, 3) != 0) ? 4'($urandom_range(1, 3)) : 4'($urandom),
                          4'($urandom));
            else
                send_item(3'($urandom_range(5, 7)), 3'($urandom), 3'($urandom), 8'($urandom),
                          4'($urandom), 4'($urandom));
        end
        quiet = 1'b0;
        drain_all();
    endtask

    initial begin
        errors = 0;
        quiet = 1'b0;
        stall_left = 0;
        m_ready = 1'b0;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_cmd = '0;
        s_rule_index = '0;
        s_byte_pos = '0;
        s_byte_value = '0;
        s_search_length = '0;
        s_replace_length = '0;
        for (int r = 0; r < NRULES; r++) begin
            pat_len[r] = 1;
            sub_len[r] = 1;
        end
        win_fill = 0;
        active_rules = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_load_tables();
        test_directed();
        test_random_phase(4'd8, 45);
        test_random_phase(4'd3, 30);
        test_random_phase(4'd15, 30);
        test_random_phase(4'd1, 25);
        test_random_phase(4'd0, 15);

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial begin
        #20000000;
        $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire

/* files.f */
+incdir+design
design/mpbr_pkg.sv
design/mpbr_search_mem.sv
design/mpbr_replace_mem.sv
design/multi_pattern_byte_replacer.sv
design/mpbr_checker.sv
tb/multi_pattern_byte_replacer_tb.sv
